// ===== rtl/trvm_pkg.sv =====
// Shared types, constants and the microcode table of the register-machine execute unit.
`timescale 1ns / 1ps

package trvm_pkg;

    localparam int NUM_REGS    = 32;
    localparam int REG_ADDR_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_FIELD_W = 5;
    localparam int KIND_W      = 4;
    localparam int DATA_W      = 64;
    localparam int DIST_W      = 16;
    localparam int UPC_W       = 5;

    localparam logic [REG_FIELD_W-1:0] REPORT_RESET = REG_FIELD_W'(6);
    localparam logic [DIST_W-1:0]      OFFSET_ONE   = DIST_W'(1);

    typedef enum logic [KIND_W-1:0] {
        OP_CONST = 4'd0,
        OP_MOV   = 4'd1,
        OP_JMP   = 4'd2,
        OP_JLT   = 4'd3,
        OP_JEQ   = 4'd4,
        OP_ADD   = 4'd5,
        OP_MOD   = 4'd6,
        OP_NOP   = 4'd7,
        OP_END   = 4'd8
    } op_t;

    // Register file read address source.
    typedef enum logic [2:0] {
        RS_NONE,
        RS_A,
        RS_B,
        RS_C,
        RS_REPORT
    } rsel_t;

    // Register file write data source; the write address is always reg_a.
    typedef enum logic [2:0] {
        WS_NONE,
        WS_IMM,
        WS_RDATA,
        WS_SUM,
        WS_REM
    } wsel_t;

    typedef enum logic [1:0] {
        OF_ONE,
        OF_DIST,
        OF_LT,
        OF_NE
    } ofs_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_DONE,
        BR_DONE_IF_ZERO,
        BR_WAIT
    } br_t;

    typedef struct packed {
        rsel_t rsel;
        logic  ld_x;
        wsel_t wsel;
        ofs_t  ofs;
        br_t   br;
        logic  div_start;
        logic  halt;
    } uword_t;

    typedef struct packed {
        uword_t word;
        logic   busy;
        logic   go;
        logic   finish;
    } seq_ctrl_t;

    typedef struct packed {
        logic rd_zero;
        logic div_busy;
        logic out_stall;
    } seq_status_t;

    // Entry points of the microprogram, one per opcode.
    localparam logic [UPC_W-1:0] UPC_CONST = UPC_W'(0);
    localparam logic [UPC_W-1:0] UPC_MOV   = UPC_W'(1);
    localparam logic [UPC_W-1:0] UPC_MOV_1 = UPC_W'(2);
    localparam logic [UPC_W-1:0] UPC_JMP   = UPC_W'(3);
    localparam logic [UPC_W-1:0] UPC_JLT   = UPC_W'(4);
    localparam logic [UPC_W-1:0] UPC_JLT_1 = UPC_W'(5);
    localparam logic [UPC_W-1:0] UPC_JLT_2 = UPC_W'(6);
    localparam logic [UPC_W-1:0] UPC_JEQ   = UPC_W'(7);
    localparam logic [UPC_W-1:0] UPC_JEQ_1 = UPC_W'(8);
    localparam logic [UPC_W-1:0] UPC_JEQ_2 = UPC_W'(9);
    localparam logic [UPC_W-1:0] UPC_ADD   = UPC_W'(10);
    localparam logic [UPC_W-1:0] UPC_ADD_1 = UPC_W'(11);
    localparam logic [UPC_W-1:0] UPC_ADD_2 = UPC_W'(12);
    localparam logic [UPC_W-1:0] UPC_MOD   = UPC_W'(13);
    localparam logic [UPC_W-1:0] UPC_MOD_1 = UPC_W'(14);
    localparam logic [UPC_W-1:0] UPC_MOD_2 = UPC_W'(15);
    localparam logic [UPC_W-1:0] UPC_MOD_3 = UPC_W'(16);
    localparam logic [UPC_W-1:0] UPC_MOD_4 = UPC_W'(17);
    localparam logic [UPC_W-1:0] UPC_NOP   = UPC_W'(18);
    localparam logic [UPC_W-1:0] UPC_END   = UPC_W'(19);
    localparam logic [UPC_W-1:0] UPC_END_1 = UPC_W'(20);

    function automatic logic [UPC_W-1:0] entry_point(input logic [KIND_W-1:0] kind);
        logic [UPC_W-1:0] e;
        case (kind)
            OP_CONST: e = UPC_CONST;
            OP_MOV:   e = UPC_MOV;
            OP_JMP:   e = UPC_JMP;
            OP_JLT:   e = UPC_JLT;
            OP_JEQ:   e = UPC_JEQ;
            OP_ADD:   e = UPC_ADD;
            OP_MOD:   e = UPC_MOD;
            OP_END:   e = UPC_END;
            default:  e = UPC_NOP;
        endcase
        return e;
    endfunction

    // A read issued in one step delivers its data in the following step.
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
        uword_t w;
        w.rsel      = RS_NONE;
        w.ld_x      = 1'b0;
        w.wsel      = WS_NONE;
        w.ofs       = OF_ONE;
        w.br        = BR_NEXT;
        w.div_start = 1'b0;
        w.halt      = 1'b0;
        case (upc)
            UPC_CONST:
            begin
                w.wsel = WS_IMM;
                w.br   = BR_DONE;
            end
            UPC_MOV:
            begin
                w.rsel = RS_B;
            end
            UPC_MOV_1:
            begin
                w.wsel = WS_RDATA;
                w.br   = BR_DONE;
            end
            UPC_JMP:
            begin
                w.ofs = OF_DIST;
                w.br  = BR_DONE;
            end
            UPC_JLT, UPC_JEQ:
            begin
                w.rsel = RS_A;
            end
            UPC_JLT_1, UPC_JEQ_1, UPC_ADD_1, UPC_MOD_1:
            begin
                w.ld_x = 1'b1;
                w.rsel = (upc == UPC_ADD_1 || upc == UPC_MOD_1) ? RS_C : RS_B;
            end
            UPC_JLT_2:
            begin
                w.ofs = OF_LT;
                w.br  = BR_DONE;
            end
            UPC_JEQ_2:
            begin
                w.ofs = OF_NE;
                w.br  = BR_DONE;
            end
            UPC_ADD, UPC_MOD:
            begin
                w.rsel = RS_B;
            end
            UPC_ADD_2:
            begin
                w.wsel = WS_SUM;
                w.br   = BR_DONE;
            end
            UPC_MOD_2:
            begin
                w.div_start = 1'b1;
                w.br        = BR_DONE_IF_ZERO;
            end
            UPC_MOD_3:
            begin
                w.br = BR_WAIT;
            end
            UPC_MOD_4:
            begin
                w.wsel = WS_REM;
                w.br   = BR_DONE;
            end
            UPC_END:
            begin
                w.rsel = RS_REPORT;
            end
            UPC_END_1:
            begin
                w.halt = 1'b1;
                w.br   = BR_DONE;
            end
            default:
            begin
                w.br = BR_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/trvm_instr_if.sv =====
// Instruction channel: valid/ready handshake with the instruction fields.
`timescale 1ns / 1ps

interface trvm_instr_if import trvm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [REG_FIELD_W-1:0]  reg_a;
    logic [REG_FIELD_W-1:0]  reg_b;
    logic [REG_FIELD_W-1:0]  reg_c;
    logic signed [DATA_W-1:0] immediate;
    logic signed [DIST_W-1:0] jump_distance;

    modport source (
        output valid, kind, reg_a, reg_b, reg_c, immediate, jump_distance,
        input  ready
    );

    modport sink (
        input  valid, kind, reg_a, reg_b, reg_c, immediate, jump_distance,
        output ready
    );
endinterface

// ===== rtl/trvm_result_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface trvm_result_if import trvm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] next_offset;
    logic                     halted;
    logic                     divide_fault;
    logic signed [DATA_W-1:0] reported_value;

    modport source (
        output valid, next_offset, halted, divide_fault, reported_value,
        input  ready
    );

    modport sink (
        input  valid, next_offset, halted, divide_fault, reported_value,
        output ready
    );
endinterface

// ===== rtl/trvm_regfile.sv =====
// Register file: one write and one registered read port, with per-entry valid bits.
`timescale 1ns / 1ps

module trvm_regfile import trvm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  logic [REG_FIELD_W-1:0] waddr,
    input  logic [DATA_W-1:0]      wdata,
    input  logic                   re,
    input  logic [REG_FIELD_W-1:0] raddr,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rdata_reg;
    logic                rvalid_reg;
    logic                w_in_range;
    logic                r_in_range;
    logic [REG_ADDR_W-1:0] waddr_i;
    logic [REG_ADDR_W-1:0] raddr_i;

    // Indices past the end of the file read as zero and ignore writes.
    assign w_in_range = int'(waddr) < NUM_REGS;
    assign r_in_range = int'(raddr) < NUM_REGS;
    assign waddr_i    = REG_ADDR_W'(waddr);
    assign raddr_i    = REG_ADDR_W'(raddr);

    always_ff @(posedge clk)
    begin
        if (we && w_in_range)
        begin
            mem[waddr_i] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr_i];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we && w_in_range)
            begin
                valid_reg[waddr_i] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= r_in_range && valid_reg[raddr_i];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/trvm_divider.sv =====
// Bit-serial signed remainder unit, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module trvm_divider import trvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic              neg_reg;
    logic [DATA_W:0]   partial;
    logic [DATA_W:0]   trial;

    assign partial = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = partial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DATA_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Restoring division on magnitudes; the sign of the dividend is applied at the end.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
            dsr_reg <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
            neg_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[DATA_W] ? partial[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    assign busy      = busy_reg;
    assign remainder = neg_reg ? (~rem_reg + DATA_W'(1)) : rem_reg;

endmodule

// ===== rtl/trvm_sequencer.sv =====
// Microcode sequencer: step counter, opcode dispatch and conditional branching.
`timescale 1ns / 1ps

module trvm_sequencer import trvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  seq_status_t       status,
    output seq_ctrl_t         ctrl
);

    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           word;
    logic             finish;
    logic             stall;
    logic             go;

    assign word   = ucode_rom(upc_reg);
    assign finish = (word.br == BR_DONE) || (word.br == BR_DONE_IF_ZERO && status.rd_zero);
    // A finishing step waits for room in the output register; the wait step for the divider.
    assign stall  = (finish && status.out_stall) || (word.br == BR_WAIT && status.div_busy);
    assign go     = busy_reg && !stall;

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                upc_next  = entry_point(kind);
            end
        end
        else if (go)
        begin
            if (finish)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    always_comb
    begin
        ctrl.word   = word;
        ctrl.busy   = busy_reg;
        ctrl.go     = go;
        ctrl.finish = finish;
    end

endmodule

// ===== rtl/tiny_register_vm_execute.sv =====
// Top level of the register-machine execute unit: datapath around the microcode sequencer.
// One instruction at a time; a new one is accepted in the cycle after the previous one finishes.
// Each instruction runs through its microcode steps, at most one register-file read per step;
// mod also waits in a step for the bit-serial remainder unit to finish its 64 iterations.
// Reset (rst_n, asynchronous) idles the sequencer, clears the per-entry valid bits so every
// register reads as zero, and sets the report select register to 6; no clearing pass is needed.
`timescale 1ns / 1ps

module tiny_register_vm_execute import trvm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    trvm_instr_if.sink             instr,
    trvm_result_if.source          result,
    input  logic                   cfg_wr_en,
    input  logic [REG_FIELD_W-1:0] cfg_wr_data
);

    seq_ctrl_t   ctrl;
    seq_status_t status;
    logic        accept;

    logic [REG_FIELD_W-1:0] report_sel_reg;
    logic [REG_FIELD_W-1:0] ra_reg;
    logic [REG_FIELD_W-1:0] rb_reg;
    logic [REG_FIELD_W-1:0] rc_reg;
    logic [DATA_W-1:0]      imm_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [DATA_W-1:0]      x_reg;

    logic                   rf_we;
    logic                   rf_re;
    logic [REG_FIELD_W-1:0] rf_raddr;
    logic [DATA_W-1:0]      rf_wdata;
    logic [DATA_W-1:0]      rf_rdata;
    logic                   div_start;
    logic                   div_busy;
    logic [DATA_W-1:0]      div_rem;
    logic                   emit;

    logic                   out_valid_reg;
    logic [DIST_W-1:0]      offset_reg;
    logic [DIST_W-1:0]      offset_next;
    logic                   halted_reg;
    logic                   fault_reg;
    logic [DATA_W-1:0]      report_reg;

    assign instr.ready = !ctrl.busy;
    assign accept      = instr.valid && instr.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_sel_reg <= REPORT_RESET;
        end
        else if (cfg_wr_en)
        begin
            report_sel_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ra_reg   <= instr.reg_a;
            rb_reg   <= instr.reg_b;
            rc_reg   <= instr.reg_c;
            imm_reg  <= instr.immediate;
            dist_reg <= instr.jump_distance;
        end
        if (ctrl.go && ctrl.word.ld_x)
        begin
            x_reg <= rf_rdata;
        end
    end

    assign status.rd_zero   = (rf_rdata == '0);
    assign status.div_busy  = div_busy;
    assign status.out_stall = out_valid_reg && !result.ready;

    trvm_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .kind   (instr.kind),
        .status (status),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        case (ctrl.word.rsel)
            RS_A:      rf_raddr = ra_reg;
            RS_B:      rf_raddr = rb_reg;
            RS_C:      rf_raddr = rc_reg;
            RS_REPORT: rf_raddr = report_sel_reg;
            default:   rf_raddr = ra_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.word.wsel)
            WS_IMM:   rf_wdata = imm_reg;
            WS_RDATA: rf_wdata = rf_rdata;
            WS_SUM:   rf_wdata = x_reg + rf_rdata;
            WS_REM:   rf_wdata = div_rem;
            default:  rf_wdata = imm_reg;
        endcase
    end

    assign rf_re     = ctrl.go && (ctrl.word.rsel != RS_NONE);
    assign rf_we     = ctrl.go && (ctrl.word.wsel != WS_NONE);
    assign div_start = ctrl.go && ctrl.word.div_start && !status.rd_zero;

    trvm_regfile u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (ra_reg),
        .wdata (rf_wdata),
        .re    (rf_re),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    trvm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (x_reg),
        .divisor   (rf_rdata),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // Jump tests fall through when they hold and take the distance otherwise.
    always_comb
    begin
        case (ctrl.word.ofs)
            OF_DIST: offset_next = dist_reg;
            OF_LT:   offset_next = ($signed(x_reg) < $signed(rf_rdata)) ? OFFSET_ONE : dist_reg;
            OF_NE:   offset_next = (x_reg != rf_rdata) ? dist_reg : OFFSET_ONE;
            default: offset_next = OFFSET_ONE;
        endcase
    end

    assign emit = ctrl.go && ctrl.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            offset_reg <= offset_next;
            halted_reg <= ctrl.word.halt;
            fault_reg  <= (ctrl.word.br == BR_DONE_IF_ZERO);
            report_reg <= ctrl.word.halt ? rf_rdata : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.next_offset    = offset_reg;
    assign result.halted         = halted_reg;
    assign result.divide_fault   = fault_reg;
    assign result.reported_value = report_reg;

    // A finished transaction never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && !result.ready))
        else $error("result register overwritten while held");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_wait_for_div: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we && (ctrl.word.wsel == WS_REM) |-> !div_busy)
        else $error("remainder written before the divider finished");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(halted_reg && fault_reg))
        else $error("halt and divide fault raised together");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !halted_reg |-> report_reg == '0)
        else $error("reported value nonzero outside end");

endmodule
